// ===== hdl/wdl_pkg.sv =====
// ----------------------------------------------------------------------------
// wdl_pkg
// Shared types and constants of the weighted two-tap delay line.
// ----------------------------------------------------------------------------
package wdl_pkg;

  // defaults of the top-level parameters
  localparam int DEPTH_DEF       = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // fixed register layout
  localparam int TAPS        = 2;
  localparam int CFG_LEN_W   = 11;
  localparam int WEIGHT_W    = 16;
  localparam int WEIGHT_FRAC = 14;
  localparam int CFG_DATA_W  = (CFG_LEN_W > WEIGHT_W) ? CFG_LEN_W : WEIGHT_W;
  localparam int CFG_IDX_W   = 3;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELAY_LENGTH = 3'd0,
    REG_TAP_A_DELAY  = 3'd1,
    REG_TAP_B_DELAY  = 3'd2,
    REG_TAP_A_WEIGHT = 3'd3,
    REG_TAP_B_WEIGHT = 3'd4
  } cfg_reg_t;

  // where a tap takes its value from
  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_INPUT,
    SRC_STORE
  } tap_src_t;

  // one multiply step handed from the ring control to the datapath
  typedef struct packed {
    logic     vld;
    logic     first;
    tap_src_t src;
  } mac_op_t;

  // width that holds a ring length up to depth and every tap delay
  function automatic int len_width(input int depth);
    int w;
    w = $clog2(depth + 1);
    return (w > CFG_LEN_W) ? w : CFG_LEN_W;
  endfunction

endpackage

// ===== hdl/wdl_ram.sv =====
// ----------------------------------------------------------------------------
// wdl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// A read of the address written in the same cycle returns the old data.
// ----------------------------------------------------------------------------
module wdl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, read-first
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/wdl_ring.sv =====
// ----------------------------------------------------------------------------
// wdl_ring
// Ring control: clearing pass, write position, tap address generation and
// the read schedule of the delay store, tap a then tap b.
// ----------------------------------------------------------------------------
module wdl_ring
  import wdl_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [SAMPLE_BITS-1:0]             sample_in,
  input  logic                               room,
  input  logic [len_width(DEPTH)-1:0]        delay_length,
  input  logic [TAPS-1:0][CFG_LEN_W-1:0]     tap_delay,
  input  logic                               len_wr,
  output logic                               ram_we,
  output logic [$clog2(DEPTH)-1:0]           ram_waddr,
  output logic [SAMPLE_BITS-1:0]             ram_wdata,
  output logic                               ram_re,
  output logic [$clog2(DEPTH)-1:0]           ram_raddr,
  output mac_op_t                            op,
  output logic [SAMPLE_BITS-1:0]             op_x,
  output logic                               take
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = len_width(DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  logic                   clr_busy;
  logic [AW-1:0]          clr_addr;
  logic [AW-1:0]          wp;
  logic [AW-1:0]          wp_next;
  logic [LW-1:0]          wp_inc;
  logic                   ph;
  logic                   bpend;
  logic [SAMPLE_BITS-1:0] x_r;
  tap_src_t               src_a_r;
  tap_src_t               src_b_r;
  logic [AW-1:0]          addr_b_r;
  logic [AW-1:0]          wa_r;

  tap_src_t               tap_src  [TAPS];
  logic [AW-1:0]          tap_addr [TAPS];

  // tap address and source from the current write position
  for (genvar t = 0; t < TAPS; t++) begin : g_tap
    logic [LW-1:0] d;
    logic [LW-1:0] wpx;
    logic [LW-1:0] diff;
    logic [LW:0]   wrap;

    assign d    = LW'(tap_delay[t]);
    assign wpx  = LW'(wp);
    assign diff = wpx - d;
    assign wrap = {1'b0, wpx} + {1'b0, delay_length} - {1'b0, d};

    always_comb begin
      if (d == '0) begin
        tap_src[t] = SRC_INPUT;
      end else if (d <= delay_length) begin
        tap_src[t] = SRC_STORE;
      end else begin
        tap_src[t] = SRC_NONE;
      end
      if (wpx >= d) begin
        tap_addr[t] = diff[AW-1:0];
      end else begin
        tap_addr[t] = wrap[AW-1:0];
      end
    end
  end

  // handshake: no word during the clearing pass, a tap b read or with no free queue slot
  assign in_ready = !clr_busy && !ph && room;
  assign take     = in_valid && in_ready;

  // next write position, wraps at the active length
  assign wp_inc  = LW'(wp) + LW'(1);
  assign wp_next = (wp_inc >= delay_length) ? '0 : wp_inc[AW-1:0];

  // store write: zero sweep after reset, else the accepted word in the
  // cycle after accept, so both tap reads still see the old slot
  assign ram_we    = clr_busy || ph;
  assign ram_waddr = clr_busy ? clr_addr : wa_r;
  assign ram_wdata = clr_busy ? '0 : x_r;

  // store read: tap a on accept, tap b in the following cycle
  assign ram_re    = take || ph;
  assign ram_raddr = ph ? addr_b_r : tap_addr[0];

  // multiply step for the data returning from the store
  always_comb begin
    op.vld   = ph || bpend;
    op.first = ph;
    if (ph) begin
      op.src = src_a_r;
    end else if (bpend) begin
      op.src = src_b_r;
    end else begin
      op.src = SRC_NONE;
    end
  end
  assign op_x = x_r;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
      wp       <= '0;
      ph       <= 1'b0;
      bpend    <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_addr == LAST_ADDR) begin
          clr_busy <= 1'b0;
        end
      end
      if (len_wr) begin
        wp <= '0;
      end else if (take) begin
        wp <= wp_next;
      end
      ph    <= take;
      bpend <= ph;
    end
  end

  // per-word payload
  always_ff @(posedge clk) begin
    if (take) begin
      x_r      <= sample_in;
      src_a_r  <= tap_src[0];
      src_b_r  <= tap_src[1];
      addr_b_r <= tap_addr[1];
      wa_r     <= wp;
    end
  end

endmodule

// ===== hdl/wdl_mac.sv =====
// ----------------------------------------------------------------------------
// wdl_mac
// Shared tap multiplier, sum, rounding and saturation, and the result queue
// with its credit count toward the input side.
// ----------------------------------------------------------------------------
module wdl_mac
  import wdl_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mac_op_t                       op,
  input  logic [SAMPLE_BITS-1:0]        op_x,
  input  logic [SAMPLE_BITS-1:0]        rd_data,
  input  logic [TAPS-1:0][WEIGHT_W-1:0] tap_weight,
  input  logic                          take,
  output logic                          room,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SAMPLE_BITS-1:0]        sample_out
);

  localparam int PW      = SAMPLE_BITS + WEIGHT_W;
  localparam int ACW     = PW + 1;
  localparam int RW      = ACW + 1;
  localparam int Q_DEPTH = 4;
  localparam int QAW     = $clog2(Q_DEPTH);
  localparam int CW      = QAW + 1;

  localparam logic signed [RW-1:0] RND_HALF = RW'(1) << (WEIGHT_FRAC - 1);
  localparam logic signed [RW-1:0] SAT_HI =
    {{(RW - SAMPLE_BITS + 1){1'b0}}, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO =
    {{(RW - SAMPLE_BITS + 1){1'b1}}, {(SAMPLE_BITS - 1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] val;
  logic signed [WEIGHT_W-1:0]    wgt;
  logic signed [PW-1:0]          prod;
  logic signed [PW-1:0]          prod_a;
  logic signed [ACW-1:0]         acc;
  logic                          acc_vld;
  logic signed [RW-1:0]          rnd;
  logic signed [RW-1:0]          shf;
  logic [SAMPLE_BITS-1:0]        sat;

  logic [SAMPLE_BITS-1:0]        q_data [Q_DEPTH];
  logic [QAW-1:0]                q_wr;
  logic [QAW-1:0]                q_rd;
  logic [CW-1:0]                 q_cnt;
  logic [CW-1:0]                 inflight;
  logic                          pop;

  // operand select for the shared multiplier
  always_comb begin
    case (op.src)
      SRC_INPUT: val = op_x;
      SRC_STORE: val = rd_data;
      default:   val = '0;
    endcase
  end
  assign wgt  = op.first ? tap_weight[0] : tap_weight[1];
  assign prod = val * wgt;

  // tap a product, then the exact two-tap sum
  always_ff @(posedge clk) begin
    if (op.vld && op.first) begin
      prod_a <= prod;
    end
    if (op.vld && !op.first) begin
      acc <= ACW'(prod_a) + ACW'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= 1'b0;
    end else begin
      acc_vld <= op.vld && !op.first;
    end
  end

  // round half up, then clamp to the sample range
  assign rnd = RW'(acc) + RND_HALF;
  assign shf = rnd >>> WEIGHT_FRAC;

  always_comb begin
    if (shf > SAT_HI) begin
      sat = SAT_HI[SAMPLE_BITS-1:0];
    end else if (shf < SAT_LO) begin
      sat = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat = shf[SAMPLE_BITS-1:0];
    end
  end

  // result queue
  assign out_valid  = (q_cnt != '0);
  assign sample_out = q_data[q_rd];
  assign pop        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (acc_vld) begin
      q_data[q_wr] <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr  <= '0;
      q_rd  <= '0;
      q_cnt <= '0;
    end else begin
      if (acc_vld) begin
        q_wr <= q_wr + QAW'(1);
      end
      if (pop) begin
        q_rd <= q_rd + QAW'(1);
      end
      q_cnt <= q_cnt + CW'(acc_vld) - CW'(pop);
    end
  end

  // words accepted but not yet delivered, each owns a queue slot
  assign room = (inflight != CW'(Q_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else begin
      inflight <= inflight + CW'(take) - CW'(pop);
    end
  end

endmodule

// ===== hdl/weighted_multi_tap_delay_line_unit.sv =====
// ----------------------------------------------------------------------------
// weighted_multi_tap_delay_line_unit
// Two-tap weighted audio delay line on a circular sample store.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (sample_in) arrive on in_valid/in_ready, results
//   (sample_out) leave on out_valid/out_ready, one result per input word.
//   Registers are written through cfg_wr_en/cfg_index/cfg_data only while
//   the unit is idle, a rule on the user that the unit does not enforce;
//   a delay length write also restarts the ring at slot zero, keeps samples.
//   Each word needs both tap reads from the single read port of the delay
//   store, so no word is taken while tap b of the previous word is read.
//   On its way out a word passes the store read, prod_a, acc and the queue.
//   The store write of a word happens in the cycle after its accept, with
//   the second tap read; the store reads old data on a same-address
//   access, so a tap at the full length sees the oldest sample.
//   Reset: a clearing pass writes zero to all DEPTH slots, one per cycle;
//   in_ready stays low during the pass, register writes are taken.
//   Stall: a 4-entry result queue decouples the sides; input keeps being
//   taken until 4 words are outstanding, then in_ready drops until the
//   receiver takes a result.
// ----------------------------------------------------------------------------
module weighted_multi_tap_delay_line_unit
  import wdl_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] sample_out,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = len_width(DEPTH);
  localparam logic [LW-1:0] LEN_MAX = LW'(DEPTH);

  logic [LW-1:0]                 delay_length;
  logic [TAPS-1:0][CFG_LEN_W-1:0] tap_delay;
  logic [TAPS-1:0][WEIGHT_W-1:0]  tap_weight;
  logic [LW-1:0]                 len_req;
  logic                          len_wr;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [SAMPLE_BITS-1:0]        ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [SAMPLE_BITS-1:0]        ram_rdata;

  mac_op_t                       op;
  logic [SAMPLE_BITS-1:0]        op_x;
  logic                          take;
  logic                          room;

  // register file
  assign len_req = LW'(cfg_data[CFG_LEN_W-1:0]);
  assign len_wr  = cfg_wr_en && (cfg_index == REG_DELAY_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length <= LEN_MAX;
      tap_delay    <= '0;
      tap_weight   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DELAY_LENGTH: begin
          if (len_req == '0) begin
            delay_length <= LW'(1);
          end else if (len_req > LEN_MAX) begin
            delay_length <= LEN_MAX;
          end else begin
            delay_length <= len_req;
          end
        end
        REG_TAP_A_DELAY:  tap_delay[0]  <= cfg_data[CFG_LEN_W-1:0];
        REG_TAP_B_DELAY:  tap_delay[1]  <= cfg_data[CFG_LEN_W-1:0];
        REG_TAP_A_WEIGHT: tap_weight[0] <= cfg_data[WEIGHT_W-1:0];
        REG_TAP_B_WEIGHT: tap_weight[1] <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // delay store
  wdl_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ring control and read schedule
  wdl_ring #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ring (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_in    (sample_in),
    .room         (room),
    .delay_length (delay_length),
    .tap_delay    (tap_delay),
    .len_wr       (len_wr),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .op           (op),
    .op_x         (op_x),
    .take         (take)
  );

  // weighting, sum and result queue
  wdl_mac #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac (
    .clk        (clk),
    .rst        (rst),
    .op         (op),
    .op_x       (op_x),
    .rd_data    (ram_rdata),
    .tap_weight (tap_weight),
    .take       (take),
    .room       (room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

endmodule
